>>> sv/vsa_pkg.sv
// ============================================================================
// Voice slot allocator package
// Shared sizes, operation codes and the request record that travels from the
// front end to the list engine.
// ============================================================================
package vsa_pkg;

    // Pool size and the widths that follow from it.
    localparam int VOICES = 16;
    localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int LINK_W = $clog2(VOICES + 1);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(VOICES);

    // Fixed field widths of the request and result ports.
    localparam int OP_W         = 2;
    localparam int SOUND_W      = 10;
    localparam int VOL_W        = 7;
    localparam int SLOT_PORT_W  = 4;
    localparam int COUNT_PORT_W = 5;

    localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;
    localparam logic [VOL_W-1:0] VOL_RESET = 7'd100;

    typedef enum logic [OP_W-1:0] {
        OP_ACTIVATE = 2'd0,
        OP_FINISH   = 2'd1,
        OP_CLEAR    = 2'd2
    } t_op;

    // What the list engine has to do with a request.
    typedef enum logic [1:0] {
        KIND_ACT    = 2'd0,
        KIND_FIN    = 2'd1,
        KIND_CLR    = 2'd2,
        KIND_REPORT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [SLOT_PORT_W-1:0] slot;
        logic [SOUND_W-1:0]     sound;
        logic                   loop;
        logic [VOL_W-1:0]       vol;
    } t_cmd;

endpackage

>>> sv/vsa_front.sv
// ============================================================================
// Voice slot allocator front end
// Holds the volume register, classifies each request and queues it in a
// two-entry queue for the list engine.
// ============================================================================
module vsa_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [vsa_pkg::VOL_W-1:0]        i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [vsa_pkg::OP_W-1:0]         i_operation,
    input  logic [vsa_pkg::SOUND_W-1:0]      i_sound_id,
    input  logic                             i_sound_loaded,
    input  logic                             i_loop_flag,
    input  logic [vsa_pkg::SLOT_PORT_W-1:0]  i_slot,
    output logic                             o_q_valid,
    output vsa_pkg::t_cmd                    o_q_cmd,
    input  logic                             i_q_pop
);

    logic [vsa_pkg::VOL_W-1:0] r_volume;
    logic [vsa_pkg::VOL_W-1:0] vol_sat;
    vsa_pkg::t_cmd             cmd;
    vsa_pkg::t_cmd             r_q [2];
    logic                      r_wr_ptr;
    logic                      r_rd_ptr;
    logic [1:0]                r_count;
    logic                      push;

    assign vol_sat = (r_volume > vsa_pkg::VOL_MAX) ? vsa_pkg::VOL_MAX : r_volume;

    // An activation with no volume or no sound data is only a count report.
    always_comb begin
        cmd.slot  = i_slot;
        cmd.sound = i_sound_id;
        cmd.loop  = i_loop_flag;
        cmd.vol   = vol_sat;
        unique case (vsa_pkg::t_op'(i_operation))
            vsa_pkg::OP_ACTIVATE: begin
                cmd.kind = ((vol_sat != '0) && i_sound_loaded) ?
                           vsa_pkg::KIND_ACT : vsa_pkg::KIND_REPORT;
            end
            vsa_pkg::OP_FINISH: cmd.kind = vsa_pkg::KIND_FIN;
            vsa_pkg::OP_CLEAR:  cmd.kind = vsa_pkg::KIND_CLR;
            default:            cmd.kind = vsa_pkg::KIND_REPORT;
        endcase
    end

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_cmd    = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= vsa_pkg::VOL_RESET;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_volume <= i_cfg_wr_data;
            end
            if (push) begin
                r_q[r_wr_ptr] <= cmd;
                r_wr_ptr      <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/vsa_back.sv
// ============================================================================
// Voice slot allocator list engine
// Keeps the free and active lists, executes one queued request at a time and
// holds its result in the output register.
// ============================================================================
module vsa_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  vsa_pkg::t_cmd                      i_q_cmd,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_granted,
    output logic [vsa_pkg::SLOT_PORT_W-1:0]    o_granted_slot,
    output logic                               o_stolen,
    output logic [vsa_pkg::VOL_W-1:0]          o_voice_volume,
    output logic                               o_voice_loop,
    output logic [vsa_pkg::SOUND_W-1:0]        o_voice_sound,
    output logic [vsa_pkg::COUNT_PORT_W-1:0]   o_active_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACT,
        S_FIN,
        S_CLR,
        S_DONE
    } t_state;

    t_state                            r_state;
    t_state                            pop_state;
    vsa_pkg::t_cmd                     r_cmd;

    logic [vsa_pkg::LINK_W-1:0]        r_link_next [vsa_pkg::VOICES];
    logic [vsa_pkg::LINK_W-1:0]        r_link_prev [vsa_pkg::VOICES];
    logic                              r_is_active [vsa_pkg::VOICES];
    logic [vsa_pkg::LINK_W-1:0]        r_active_head;
    logic [vsa_pkg::LINK_W-1:0]        r_active_tail;
    logic [vsa_pkg::LINK_W-1:0]        r_free_head;
    logic [vsa_pkg::LINK_W-1:0]        r_total;

    logic                              r_res_granted;
    logic [vsa_pkg::SLOT_PORT_W-1:0]   r_res_slot;
    logic                              r_res_stolen;

    logic                              r_out_valid;
    logic                              r_granted;
    logic [vsa_pkg::SLOT_PORT_W-1:0]   r_granted_slot;
    logic                              r_stolen;
    logic [vsa_pkg::VOL_W-1:0]         r_voice_volume;
    logic                              r_voice_loop;
    logic [vsa_pkg::SOUND_W-1:0]       r_voice_sound;
    logic [vsa_pkg::COUNT_PORT_W-1:0]  r_active_count;

    logic                              out_free;
    logic                              pop;
    logic [vsa_pkg::SLOT_W-1:0]        slot_idx;
    logic                              fin_hit;
    logic [vsa_pkg::LINK_W-1:0]        rel_addr;
    logic [vsa_pkg::LINK_W-1:0]        rd_next_addr;
    logic [vsa_pkg::LINK_W-1:0]        rd_next;
    logic [vsa_pkg::LINK_W-1:0]        rel_prev;
    logic                              do_release;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = i_q_valid && ((r_state == S_IDLE) || ((r_state == S_DONE) && out_free));
    assign o_q_pop  = pop;

    always_comb begin
        unique case (i_q_cmd.kind)
            vsa_pkg::KIND_ACT: pop_state = S_ACT;
            vsa_pkg::KIND_FIN: pop_state = S_FIN;
            vsa_pkg::KIND_CLR: pop_state = S_CLR;
            default:           pop_state = S_DONE;
        endcase
    end

    // One read port per link array: the release target, or the free head
    // while an activation is being carried out.
    assign slot_idx     = vsa_pkg::SLOT_W'(r_cmd.slot);
    assign fin_hit      = (32'(r_cmd.slot) < vsa_pkg::VOICES) && r_is_active[slot_idx];
    assign rel_addr     = (r_state == S_CLR) ? r_active_head :
                          vsa_pkg::LINK_W'(r_cmd.slot);
    assign rd_next_addr = (r_state == S_ACT) ? r_free_head : rel_addr;
    assign rd_next      = r_link_next[vsa_pkg::SLOT_W'(rd_next_addr)];
    assign rel_prev     = r_link_prev[vsa_pkg::SLOT_W'(rel_addr)];
    assign do_release   = ((r_state == S_FIN) && fin_hit) ||
                          ((r_state == S_CLR) && (r_active_head != vsa_pkg::LINK_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vsa_pkg::VOICES; i++) begin
                r_link_next[i] <= vsa_pkg::LINK_W'(i + 1);
                r_link_prev[i] <= vsa_pkg::LINK_NONE;
                r_is_active[i] <= 1'b0;
            end
            r_state       <= S_IDLE;
            r_active_head <= vsa_pkg::LINK_NONE;
            r_active_tail <= vsa_pkg::LINK_NONE;
            r_free_head   <= '0;
            r_total       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // In the done state the output register is reloaded instead.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_state <= pop_state;
                    end
                end
                S_ACT: begin
                    if (r_free_head != vsa_pkg::LINK_NONE) begin
                        r_free_head <= rd_next;
                        r_link_next[vsa_pkg::SLOT_W'(r_free_head)] <= r_active_head;
                        r_link_prev[vsa_pkg::SLOT_W'(r_free_head)] <= vsa_pkg::LINK_NONE;
                        if (r_active_head != vsa_pkg::LINK_NONE) begin
                            r_link_prev[vsa_pkg::SLOT_W'(r_active_head)] <= r_free_head;
                        end else begin
                            r_active_tail <= r_free_head;
                        end
                        r_active_head <= r_free_head;
                        r_is_active[vsa_pkg::SLOT_W'(r_free_head)] <= 1'b1;
                        r_total       <= r_total + vsa_pkg::LINK_W'(1);
                        r_res_granted <= 1'b1;
                        r_res_slot    <= vsa_pkg::SLOT_PORT_W'(r_free_head);
                    end else if (r_active_tail != vsa_pkg::LINK_NONE) begin
                        // Pool exhausted: the oldest voice is reused in place.
                        r_res_granted <= 1'b1;
                        r_res_stolen  <= 1'b1;
                        r_res_slot    <= vsa_pkg::SLOT_PORT_W'(r_active_tail);
                    end
                    r_state <= S_DONE;
                end
                S_FIN: begin
                    r_state <= S_DONE;
                end
                S_CLR: begin
                    if (r_active_head == vsa_pkg::LINK_NONE) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_granted      <= r_res_granted;
                        r_granted_slot <= r_res_slot;
                        r_stolen       <= r_res_stolen;
                        r_voice_volume <= r_res_granted ? r_cmd.vol : '0;
                        r_voice_loop   <= r_res_granted && r_cmd.loop;
                        r_voice_sound  <= r_res_granted ? r_cmd.sound : '0;
                        r_active_count <= vsa_pkg::COUNT_PORT_W'(r_total);
                        r_state        <= pop ? pop_state : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Unlink one active voice and push it onto the free head.
            if (do_release) begin
                if (rel_prev != vsa_pkg::LINK_NONE) begin
                    r_link_next[vsa_pkg::SLOT_W'(rel_prev)] <= rd_next;
                end else begin
                    r_active_head <= rd_next;
                end
                if (rd_next != vsa_pkg::LINK_NONE) begin
                    r_link_prev[vsa_pkg::SLOT_W'(rd_next)] <= rel_prev;
                end else begin
                    r_active_tail <= rel_prev;
                end
                r_is_active[vsa_pkg::SLOT_W'(rel_addr)] <= 1'b0;
                r_link_prev[vsa_pkg::SLOT_W'(rel_addr)] <= vsa_pkg::LINK_NONE;
                r_link_next[vsa_pkg::SLOT_W'(rel_addr)] <= r_free_head;
                r_free_head <= rel_addr;
                if (r_total != '0) begin
                    r_total <= r_total - vsa_pkg::LINK_W'(1);
                end
            end

            if (pop) begin
                r_cmd         <= i_q_cmd;
                r_res_granted <= 1'b0;
                r_res_slot    <= '0;
                r_res_stolen  <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_granted;
    assign o_granted_slot = r_granted_slot;
    assign o_stolen       = r_stolen;
    assign o_voice_volume = r_voice_volume;
    assign o_voice_loop   = r_voice_loop;
    assign o_voice_sound  = r_voice_sound;
    assign o_active_count = r_active_count;

endmodule

>>> sv/voice_slot_allocator_unit.sv
// ============================================================================
// Voice slot allocator
// Fixed pool of voice slots with a LIFO free list and a newest-first active
// list; activations reuse the oldest voice when the pool is exhausted.
// ============================================================================
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------------
//  config    i_cfg_wr_en             i_cfg_wr_data (volume)
//  request   i_in_valid / o_in_stall operation, sound_id, sound_loaded,
//                                    loop_flag, slot
//  result    o_out_valid / i_out_stall granted, granted_slot, stolen,
//                                    voice_volume, voice_loop, voice_sound,
//                                    active_count
//
// An activate or finish request first executes in the list engine and then
// loads the output register; the next queued request is taken as that
// result is loaded. A refused activation or an unused operation skips the
// execute step. A clear stays in its execute step until the active list is
// empty, since the engine unlinks one voice per cycle.
// Reset is synchronous: the slot lists live in flip-flops, so there is no
// clearing pass.
// A stalled result waits in the output register while a two-entry queue
// keeps taking requests; o_in_stall rises only when that queue is full.
//
// The front end saturates the volume, turns activations with zero volume or
// missing sound data into plain count reports, and queues the request. The
// list engine owns all link state and produces exactly one result for each
// request, in order.
module voice_slot_allocator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [vsa_pkg::VOL_W-1:0]          i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [vsa_pkg::OP_W-1:0]           i_operation,
    input  logic [vsa_pkg::SOUND_W-1:0]        i_sound_id,
    input  logic                               i_sound_loaded,
    input  logic                               i_loop_flag,
    input  logic [vsa_pkg::SLOT_PORT_W-1:0]    i_slot,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_granted,
    output logic [vsa_pkg::SLOT_PORT_W-1:0]    o_granted_slot,
    output logic                               o_stolen,
    output logic [vsa_pkg::VOL_W-1:0]          o_voice_volume,
    output logic                               o_voice_loop,
    output logic [vsa_pkg::SOUND_W-1:0]        o_voice_sound,
    output logic [vsa_pkg::COUNT_PORT_W-1:0]   o_active_count
);

    logic          q_valid;
    vsa_pkg::t_cmd q_cmd;
    logic          q_pop;

    // Front end: volume register, request classification and the queue.
    vsa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_sound_id     (i_sound_id),
        .i_sound_loaded (i_sound_loaded),
        .i_loop_flag    (i_loop_flag),
        .i_slot         (i_slot),
        .o_q_valid      (q_valid),
        .o_q_cmd        (q_cmd),
        .i_q_pop        (q_pop)
    );

    // List engine: free and active lists plus the output register.
    vsa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted      (o_granted),
        .o_granted_slot (o_granted_slot),
        .o_stolen       (o_stolen),
        .o_voice_volume (o_voice_volume),
        .o_voice_loop   (o_voice_loop),
        .o_voice_sound  (o_voice_sound),
        .o_active_count (o_active_count)
    );

    // A voice is only stolen when every slot is already playing.
    a_steal_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stolen) |->
            (o_granted && (o_active_count == vsa_pkg::COUNT_PORT_W'(vsa_pkg::VOICES))))
        else $error("voice stolen while the pool was not full");

    // A result that grants nothing carries no voice settings.
    a_refusal_is_clean: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |->
            (!o_stolen && (o_granted_slot == '0) && (o_voice_volume == '0) &&
             !o_voice_loop && (o_voice_sound == '0)))
        else $error("refused request reports voice settings");

    // A granted voice always plays at a legal, nonzero volume.
    a_grant_volume: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted) |->
            ((o_voice_volume != '0) && (o_voice_volume <= vsa_pkg::VOL_MAX)))
        else $error("granted voice with an illegal volume");

    // The queue is empty right after reset, so requests are taken at once.
    a_ready_after_reset: assert property (
        @(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_in_stall)
        else $error("request channel stalled right after reset");

endmodule

>>> tb/vsa_tb_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// Voice allocation tracker
// Result record and scoreboard for the voice slot allocator testbench. The
// tracker keeps its own copy of the slot lists, predicts the result of every
// accepted request and checks the results that the block returns in order.
// ============================================================================
package vsa_tb_pkg;

    // Operation code that the block must ignore, apart from reporting the count.
    localparam logic [vsa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                             granted;
        logic [vsa_pkg::SLOT_PORT_W-1:0]  granted_slot;
        logic                             stolen;
        logic [vsa_pkg::VOL_W-1:0]        voice_volume;
        logic                             voice_loop;
        logic [vsa_pkg::SOUND_W-1:0]      voice_sound;
        logic [vsa_pkg::COUNT_PORT_W-1:0] active_count;
    } t_voice_grant;

    class t_voice_alloc_tracker;

        logic [vsa_pkg::LINK_W-1:0] next_link [vsa_pkg::VOICES];
        logic [vsa_pkg::LINK_W-1:0] prev_link [vsa_pkg::VOICES];
        logic                       busy      [vsa_pkg::VOICES];
        logic [vsa_pkg::LINK_W-1:0] head;
        logic [vsa_pkg::LINK_W-1:0] tail;
        logic [vsa_pkg::LINK_W-1:0] free_head;
        int unsigned                total;
        logic [vsa_pkg::VOL_W-1:0]  volume;
        t_voice_grant               pending_grants [$];
        int unsigned                errors;

        // State after reset: every slot free, chained in slot order.
        function new();
            for (int i = 0; i < vsa_pkg::VOICES; i++) begin
                next_link[i] = vsa_pkg::LINK_W'(i + 1);
                prev_link[i] = vsa_pkg::LINK_NONE;
                busy[i]      = 1'b0;
            end
            head      = vsa_pkg::LINK_NONE;
            tail      = vsa_pkg::LINK_NONE;
            free_head = '0;
            total     = 0;
            volume    = vsa_pkg::VOL_RESET;
            errors    = 0;
        endfunction

        function void set_volume(logic [vsa_pkg::VOL_W-1:0] value);
            volume = value;
        endfunction

        function int pending();
            return pending_grants.size();
        endfunction

        // A random slot that is playing now, or -1 when none is.
        function int pick_active();
            int playing [$];
            for (int i = 0; i < vsa_pkg::VOICES; i++)
                if (busy[i]) playing = {playing, i};
            if (playing.size() == 0) return -1;
            return playing[$urandom_range(playing.size() - 1)];
        endfunction

        // Unlink one voice from the active list and push it onto the free head.
        function void release_voice(logic [vsa_pkg::LINK_W-1:0] s);
            logic [vsa_pkg::LINK_W-1:0] p;
            logic [vsa_pkg::LINK_W-1:0] n;
            p = prev_link[s];
            n = next_link[s];
            if (p != vsa_pkg::LINK_NONE) next_link[p] = n; else head = n;
            if (n != vsa_pkg::LINK_NONE) prev_link[n] = p; else tail = p;
            busy[s]      = 1'b0;
            prev_link[s] = vsa_pkg::LINK_NONE;
            next_link[s] = free_head;
            free_head    = s;
            if (total > 0) total--;
        endfunction

        function void predict_request(logic [vsa_pkg::OP_W-1:0] op,
                                      logic [vsa_pkg::SOUND_W-1:0] sound,
                                      logic loaded, logic loop,
                                      logic [vsa_pkg::SLOT_PORT_W-1:0] slot);
            t_voice_grant               r;
            logic [vsa_pkg::LINK_W-1:0] s;
            logic [vsa_pkg::VOL_W-1:0]  vol;
            r   = '0;
            vol = (volume > vsa_pkg::VOL_MAX) ? vsa_pkg::VOL_MAX : volume;
            if (op == vsa_pkg::OP_ACTIVATE) begin
                if (vol != 0 && loaded) begin
                    if (free_head == vsa_pkg::LINK_NONE) begin
                        // Pool exhausted: the oldest voice is reused in place.
                        s        = tail;
                        r.stolen = 1'b1;
                    end else begin
                        s            = free_head;
                        free_head    = next_link[s];
                        next_link[s] = head;
                        prev_link[s] = vsa_pkg::LINK_NONE;
                        if (head != vsa_pkg::LINK_NONE) prev_link[head] = s; else tail = s;
                        head    = s;
                        busy[s] = 1'b1;
                        total++;
                    end
                    if (s != vsa_pkg::LINK_NONE) begin
                        r.granted      = 1'b1;
                        r.granted_slot = s[vsa_pkg::SLOT_PORT_W-1:0];
                        r.voice_volume = vol;
                        r.voice_loop   = loop;
                        r.voice_sound  = sound;
                    end else begin
                        r.stolen = 1'b0;
                    end
                end
            end else if (op == vsa_pkg::OP_FINISH) begin
                if (int'(slot) < vsa_pkg::VOICES && busy[slot]) begin
                    release_voice(vsa_pkg::LINK_W'(slot));
                end
            end else if (op == vsa_pkg::OP_CLEAR) begin
                while (head != vsa_pkg::LINK_NONE) release_voice(head);
            end
            r.active_count = vsa_pkg::COUNT_PORT_W'(total);
            pending_grants = {pending_grants, r};
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_voice_grant got);
            t_voice_grant want;
            if (pending_grants.size() == 0) begin
                $error("result arrived with no request waiting for one");
                errors++;
                return;
            end
            want = pending_grants.pop_front();
            check_field("granted",      want.granted,      got.granted);
            check_field("granted_slot", want.granted_slot, got.granted_slot);
            check_field("stolen",       want.stolen,       got.stolen);
            check_field("voice_volume", want.voice_volume, got.voice_volume);
            check_field("voice_loop",   want.voice_loop,   got.voice_loop);
            check_field("voice_sound",  want.voice_sound,  got.voice_sound);
            check_field("active_count", want.active_count, got.active_count);
        endfunction

    endclass

endpackage

>>> tb/tb_voice_slot_allocator_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// Voice slot allocator testbench
// Drives requests into the allocator under random idling on both channels,
// predicts each result with an independent model of the free and active
// lists, and checks every result field in order. The volume register is
// stepped through its extremes between phases while the block is idle.
// ============================================================================
module tb_voice_slot_allocator_unit;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [vsa_pkg::VOL_W-1:0]        i_cfg_wr_data;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic [vsa_pkg::OP_W-1:0]         i_operation;
    logic [vsa_pkg::SOUND_W-1:0]      i_sound_id;
    logic                             i_sound_loaded;
    logic                             i_loop_flag;
    logic [vsa_pkg::SLOT_PORT_W-1:0]  i_slot;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic                             o_granted;
    logic [vsa_pkg::SLOT_PORT_W-1:0]  o_granted_slot;
    logic                             o_stolen;
    logic [vsa_pkg::VOL_W-1:0]        o_voice_volume;
    logic                             o_voice_loop;
    logic [vsa_pkg::SOUND_W-1:0]      o_voice_sound;
    logic [vsa_pkg::COUNT_PORT_W-1:0] o_active_count;

    // Percent of cycles in which the request side holds back, and in which
    // the result side stalls. The main sequence changes them per phase.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    vsa_tb_pkg::t_voice_alloc_tracker tracker = new();

    voice_slot_allocator_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_sound_id     (i_sound_id),
        .i_sound_loaded (i_sound_loaded),
        .i_loop_flag    (i_loop_flag),
        .i_slot         (i_slot),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted      (o_granted),
        .o_granted_slot (o_granted_slot),
        .o_stolen       (o_stolen),
        .o_voice_volume (o_voice_volume),
        .o_voice_loop   (o_voice_loop),
        .o_voice_sound  (o_voice_sound),
        .o_active_count (o_active_count)
    );

    always #5 i_clk = ~i_clk;

    // The result side decides at each falling edge whether to stall the
    // next rising edge, so the stall is stable whenever it is sampled.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // A result is taken at a rising edge with valid high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result('{o_granted, o_granted_slot, o_stolen, o_voice_volume,
                                   o_voice_loop, o_voice_sound, o_active_count});
        end
    end

    // Present one request and hold it until the block accepts it. Random idle
    // cycles come first, so gaps land at every point of the engine's work.
    task automatic send_request(input logic [vsa_pkg::OP_W-1:0] op,
                                input logic [vsa_pkg::SOUND_W-1:0] sound,
                                input logic loaded, input logic loop,
                                input logic [vsa_pkg::SLOT_PORT_W-1:0] slot);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_sound_id     <= sound;
        i_sound_loaded <= loaded;
        i_loop_flag    <= loop;
        i_slot         <= slot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.predict_request(op, sound, loaded, loop, slot);
    endtask

    // Stop sending and wait until every predicted result has been checked.
    task automatic wait_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // The volume is only written with the block idle. Once every result has
    // been checked nothing is in flight; a few spare cycles are left anyway.
    task automatic write_volume(input logic [vsa_pkg::VOL_W-1:0] value);
        wait_results();
        repeat (25) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.set_volume(value);
    endtask

    // Random requests with random content. The share of activations swings
    // between high and low so the pool both fills up (and steals) and drains.
    // Most finish requests name a slot that is actually playing.
    task automatic send_random_request(input int unsigned act_pct);
        int unsigned                     roll;
        int                              pick;
        logic [vsa_pkg::OP_W-1:0]        op;
        logic [vsa_pkg::SLOT_PORT_W-1:0] slot;
        roll = $urandom_range(99);
        slot = vsa_pkg::SLOT_PORT_W'($urandom);
        if (roll < act_pct) begin
            op = vsa_pkg::OP_ACTIVATE;
        end else if (roll < 94) begin
            op   = vsa_pkg::OP_FINISH;
            pick = tracker.pick_active();
            if (pick >= 0 && $urandom_range(3) != 0) slot = vsa_pkg::SLOT_PORT_W'(pick);
        end else if (roll < 97) begin
            op = vsa_pkg::OP_CLEAR;
        end else begin
            op = vsa_tb_pkg::OP_UNUSED;
        end
        send_request(op, vsa_pkg::SOUND_W'($urandom), ($urandom_range(9) != 0),
                     1'($urandom), slot);
    endtask

    // Volume per phase: above range (saturates), the smallest nonzero value,
    // zero (every activation refused), the top of the range, a random value
    // in between, and the top of the range again with no idling.
    int unsigned phase_volume [6] = '{127, 1, 0, 100, 50, 100};
    int unsigned phase_items  [6] = '{380, 380, 60, 380, 380, 370};

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_in_valid     = 1'b0;
        i_operation    = vsa_pkg::OP_ACTIVATE;
        i_sound_id     = '0;
        i_sound_loaded = 1'b0;
        i_loop_flag    = 1'b0;
        i_slot         = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset volume, with neither side idling.
        // A finish of a slot that is not playing and the unused operation
        // must change nothing.
        send_request(vsa_pkg::OP_FINISH, 10'd0, 1'b1, 1'b0, 4'd15);
        send_request(vsa_tb_pkg::OP_UNUSED, 10'd1023, 1'b1, 1'b1, 4'd0);
        // Smallest and largest sound ids, then a refused activation because
        // the sound is not loaded, then a clear of two voices.
        send_request(vsa_pkg::OP_ACTIVATE, 10'd0, 1'b1, 1'b0, 4'd0);
        send_request(vsa_pkg::OP_ACTIVATE, 10'd1023, 1'b1, 1'b1, 4'd15);
        send_request(vsa_pkg::OP_ACTIVATE, 10'd512, 1'b0, 1'b1, 4'd0);
        send_request(vsa_pkg::OP_CLEAR, 10'd0, 1'b0, 1'b0, 4'd0);
        // Fill the whole pool, then one more activation reuses the oldest voice.
        for (int i = 0; i < vsa_pkg::VOICES; i++) begin
            send_request(vsa_pkg::OP_ACTIVATE, vsa_pkg::SOUND_W'($urandom), 1'b1, i[0],
                         vsa_pkg::SLOT_PORT_W'($urandom));
        end
        send_request(vsa_pkg::OP_ACTIVATE, 10'd341, 1'b1, 1'b1, 4'd0);
        // Finishes of the highest slot and of one in the middle of the list.
        send_request(vsa_pkg::OP_FINISH, 10'd0, 1'b0, 1'b0, 4'd15);
        send_request(vsa_pkg::OP_FINISH, 10'd0, 1'b0, 1'b0, 4'd7);
        // Let the block run dry before a clear of the remaining voices.
        wait_results();
        send_request(vsa_pkg::OP_CLEAR, 10'd0, 1'b0, 1'b0, 4'd0);

        phase_volume[4] = $urandom_range(2, 99);
        for (int ph = 0; ph < 6; ph++) begin
            write_volume(vsa_pkg::VOL_W'(phase_volume[ph]));
            // Sender idles lightly while the receiver stalls hard, then the
            // other way round, then both sides run flat out.
            if (ph < 2) begin
                idle_pct  = 14;
                stall_pct = 50;
            end else if (ph < 4) begin
                idle_pct  = 50;
                stall_pct = 14;
            end else begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            for (int n = 0; n < phase_items[ph]; n++) begin
                if ($urandom_range(99) == 0) wait_results();
                send_random_request(((n / 40) % 2 == 0) ? 75 : 35);
            end
        end

        wait_results();
        stall_pct = 0;
        // Any extra result that shows up late is caught by the monitor.
        repeat (40) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_voice_slot_allocator_unit: clean");
        end else begin
            $display("tb_voice_slot_allocator_unit: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this sequence.
    initial begin
        #5_000_000;
        $display("tb_voice_slot_allocator_unit: errors");
        $finish;
    end

endmodule

>>> files.f
sv/vsa_pkg.sv
sv/vsa_front.sv
sv/vsa_back.sv
sv/voice_slot_allocator_unit.sv
tb/vsa_tb_pkg.sv
tb/tb_voice_slot_allocator_unit.sv
